// ===== hw/rtl/swac_pkg.sv =====
// Shared constants and the victim LFSR step function for the set-associative write-back cache.
package swac_pkg;

  localparam int NUM_WAYS   = 4;
  localparam int WAY_W      = 2;
  localparam int LINE_WORDS = 16;
  localparam int WOFF_W     = 4;
  localparam int LINE_OFF_W = 6;   // byte offset bits inside a 64-byte line
  localparam int CNT_W      = 5;   // line-copy counter, counts 0..LINE_WORDS

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [7:0] LFSR_TAPS  = 8'hB8;
  localparam logic [7:0] LFSR_RESET = 8'h01;

  // Galois LFSR, right shift
  function automatic logic [7:0] lfsr_step(input logic [7:0] cur);
    logic [7:0] nxt;
    nxt = {1'b0, cur[7:1]};
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/swac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/set_assoc_writeback_cache.sv =====
// Four-way set-associative write-back cache with its backing memory.
//
// Slave channel takes one word access per transfer: s_tuser is the command
// (read or masked write), s_tdata carries address, write data and bit mask.
// Master channel returns one result per access: m_tdata is the word at the
// address after the access, m_tuser flags hit and write-back.
//
// Steps per access after acceptance (tag divide, set row read, way lookup), then:
//   hit                    the result
//   miss, clean fill       16-word fill from backing memory, then the access
//   miss, dirty victim     16-word write-back, then the fill and the access
// The line copies run one word a cycle through the data and backing memory
// ports. The result register holds a finished result while the receiver
// stalls; the next access is accepted meanwhile, and it waits only at its
// final step until the result register is free.
//
// After reset the backing memory is cleared, one word a cycle, all MEM_BYTES/4
// words (8192 at the default); s_tready stays low meanwhile.
// Reset also invalidates every cache line and reloads the victim LFSR.
module set_assoc_writeback_cache
  import swac_pkg::*;
#(
  parameter int NUM_SETS  = 16,
  parameter int MEM_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // byte_addr[14:0], write_word[46:15], write_mask[78:47]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_word[31:0]
  output logic [1:0]  m_tuser    // was_hit[0], did_writeback[1]
);

  localparam int ADDR_W   = $clog2(MEM_BYTES);
  localparam int WADDR_W  = ADDR_W - 2;
  localparam int BLK_W    = ADDR_W - LINE_OFF_W;
  localparam int SET_L    = $clog2(NUM_SETS);
  localparam int SET_W    = (NUM_SETS > 1) ? SET_L : 1;
  localparam int TAG_CNT  = ((1 << BLK_W) + NUM_SETS - 1) / NUM_SETS;
  localparam int TAG_W    = (TAG_CNT > 1) ? $clog2(TAG_CNT) : 1;
  localparam int SHIFT    = BLK_W + SET_L;
  localparam int RECIP_W  = BLK_W + 1;
  localparam int PROD_W   = 2 * BLK_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + NUM_SETS - 1) / NUM_SETS);
  localparam int ROWS     = 1 << SET_W;
  localparam int DADDR_W  = SET_W + WAY_W + WOFF_W;
  localparam int ROW_W    = 2 * NUM_WAYS + NUM_WAYS * TAG_W;

  typedef struct packed {
    logic [NUM_WAYS-1:0]            dirty;
    logic [NUM_WAYS-1:0]            valid;
    logic [NUM_WAYS-1:0][TAG_W-1:0] tags;
  } row_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SET, S_LOOK, S_WB, S_FILL, S_ACC, S_DONE
  } state_t;

  state_t               state;
  logic [WADDR_W-1:0]   clr_cnt;
  logic                 cmd_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [31:0]          wdata_r;
  logic [31:0]          wmask_r;
  logic [TAG_W-1:0]     tag_r;
  logic [SET_W-1:0]     set_r;
  logic                 ok_r;
  logic [WAY_W-1:0]     way_r;
  logic                 hit_r;
  logic                 wb_r;
  logic [BLK_W-1:0]     vblock_r;
  logic [CNT_W-1:0]     cnt;
  logic [7:0]           lfsr;
  logic [ROWS-1:0]      row_ok;

  // memory ports
  logic                 tag_we;
  logic [SET_W-1:0]     tag_raddr;
  logic [ROW_W-1:0]     tag_rdata;
  logic                 dat_we;
  logic [DADDR_W-1:0]   dat_waddr;
  logic [31:0]          dat_wdata;
  logic [DADDR_W-1:0]   dat_raddr;
  logic [31:0]          dat_rdata;
  logic                 bk_we;
  logic [WADDR_W-1:0]   bk_waddr;
  logic [31:0]          bk_wdata;
  logic [WADDR_W-1:0]   bk_raddr;
  logic [31:0]          bk_rdata;

  logic [BLK_W-1:0]     blk;
  logic [WOFF_W-1:0]    woff;
  logic [PROD_W-1:0]    prod;
  logic [BLK_W-1:0]     set_full;
  logic [SET_W-1:0]     set_c;
  logic [WOFF_W-1:0]    cnt_m1;

  row_t                 row;
  row_t                 row_new;
  logic [NUM_WAYS-1:0]  valid_eff;
  logic [NUM_WAYS-1:0]  dirty_eff;
  logic                 hit_any;
  logic [WAY_W-1:0]     hit_way;
  logic                 inv_any;
  logic [WAY_W-1:0]     inv_way;
  logic [WAY_W-1:0]     way_sel;
  logic                 need_wb;
  logic [TAG_W-1:0]     vtag;
  logic [31:0]          merged;
  logic                 out_free;

  assign blk    = addr_r[ADDR_W-1:LINE_OFF_W];
  assign woff   = addr_r[LINE_OFF_W-1:2];
  assign cnt_m1 = WOFF_W'(cnt - CNT_W'(1));

  // tag = block / NUM_SETS by reciprocal multiply, exact over the block range
  assign prod     = PROD_W'(blk) * PROD_W'(RECIP);
  assign set_full = blk - BLK_W'(BLK_W'(tag_r) * BLK_W'(NUM_SETS));
  assign set_c    = SET_W'(set_full);

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // lookup of the set row
  always_comb begin
    row       = row_t'(tag_rdata);
    valid_eff = ok_r ? row.valid : '0;
    dirty_eff = ok_r ? row.dirty : '0;
    hit_any   = 1'b0;
    hit_way   = '0;
    inv_any   = 1'b0;
    inv_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_eff[w] && row.tags[w] == tag_r) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_eff[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    if (hit_any) begin
      way_sel = hit_way;
    end else if (inv_any) begin
      way_sel = inv_way;
    end else begin
      way_sel = lfsr[WAY_W-1:0];
    end
    need_wb = !hit_any && !inv_any && dirty_eff[lfsr[WAY_W-1:0]];
    vtag    = row.tags[way_sel];
    row_new = row;
    row_new.valid = valid_eff;
    row_new.dirty = dirty_eff;
    row_new.valid[way_sel] = 1'b1;
    row_new.tags[way_sel]  = tag_r;
    row_new.dirty[way_sel] = (hit_any && dirty_eff[way_sel]) || (cmd_r == CMD_WRITE);
  end

  assign merged = (dat_rdata & ~wmask_r) | (wdata_r & wmask_r);

  // memory port steering
  always_comb begin
    tag_raddr = set_c;
    tag_we    = (state == S_LOOK);
    dat_raddr = {set_r, way_r, woff};
    dat_we    = 1'b0;
    dat_waddr = {set_r, way_r, woff};
    dat_wdata = merged;
    bk_raddr  = {blk, cnt[WOFF_W-1:0]};
    bk_we     = 1'b0;
    bk_waddr  = {vblock_r, cnt_m1};
    bk_wdata  = dat_rdata;
    case (state)
      S_CLEAR: begin
        bk_we    = 1'b1;
        bk_waddr = clr_cnt;
        bk_wdata = '0;
      end
      S_LOOK: begin
        dat_raddr = {set_r, hit_way, woff};
      end
      S_WB: begin
        dat_raddr = {set_r, way_r, cnt[WOFF_W-1:0]};
        bk_we     = (cnt != '0);
      end
      S_FILL: begin
        dat_we    = (cnt != '0);
        dat_waddr = {set_r, way_r, cnt_m1};
        dat_wdata = bk_rdata;
      end
      S_DONE: begin
        dat_we = out_free && (cmd_r == CMD_WRITE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      lfsr     <= LFSR_RESET;
      row_ok   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // in S_DONE the result register is reloaded below instead
      if (m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + WADDR_W'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_r   <= s_tuser;
            addr_r  <= ADDR_W'(s_tdata[14:0]);
            wdata_r <= s_tdata[46:15];
            wmask_r <= s_tdata[78:47];
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          tag_r <= prod[SHIFT +: TAG_W];
          state <= S_SET;
        end
        S_SET: begin
          set_r <= set_c;
          ok_r  <= row_ok[set_c];
          state <= S_LOOK;
        end
        S_LOOK: begin
          way_r  <= way_sel;
          hit_r  <= hit_any;
          wb_r   <= need_wb;
          vblock_r <= BLK_W'(BLK_W'(vtag) * BLK_W'(NUM_SETS) + BLK_W'(set_r));
          row_ok[set_r] <= 1'b1;
          cnt    <= '0;
          if (!hit_any && !inv_any) begin
            lfsr <= lfsr_step(lfsr);
          end
          if (hit_any) begin
            state <= S_DONE;
          end else if (need_wb) begin
            state <= S_WB;
          end else begin
            state <= S_FILL;
          end
        end
        S_WB: begin
          if (cnt == CNT_W'(LINE_WORDS)) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_FILL: begin
          if (cnt == CNT_W'(LINE_WORDS)) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_ACC: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= (cmd_r == CMD_WRITE) ? merged : dat_rdata;
            m_tuser  <= {wb_r, hit_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  swac_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (set_r),
    .wdata (ROW_W'(row_new)),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  swac_ram #(.WIDTH(32), .DEPTH(ROWS * NUM_WAYS * LINE_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (dat_waddr),
    .wdata (dat_wdata),
    .raddr (dat_raddr),
    .rdata (dat_rdata)
  );

  swac_ram #(.WIDTH(32), .DEPTH(1 << WADDR_W)) u_backing_ram (
    .clk   (clk),
    .we    (bk_we),
    .waddr (bk_waddr),
    .wdata (bk_wdata),
    .raddr (bk_raddr),
    .rdata (bk_rdata)
  );

  // a write-back only happens on a miss
  a_wb_on_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("write-back flagged on a hit");

  // no access is taken while the backing memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("access accepted during clear");

  // the victim LFSR moves only on a lookup with no free way
  a_lfsr_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && (hit_any || inv_any)) |=> $stable(lfsr))
    else $error("LFSR advanced without victim choice");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != 8'h00)
    else $error("LFSR locked at zero");

endmodule

// ===== tb/sv/tb_set_assoc_writeback_cache.sv =====
// Self-checking testbench for the four-way set-associative write-back cache.
`timescale 1ns / 100ps

module tb_set_assoc_writeback_cache
  import swac_pkg::*;
();

  localparam int TB_NUM_SETS  = 16;
  localparam int TB_MEM_BYTES = 32768;
  localparam int NUM_LINES    = TB_NUM_SETS * NUM_WAYS;
  localparam int MEM_WORDS    = TB_MEM_BYTES / 4;
  localparam int N_RANDOM     = 1500;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [31:0] word;
    logic        hit;
    logic        wb;
  } cache_result_t;

  class cache_scoreboard;
    bit            line_ok [NUM_LINES];
    bit            line_mod [NUM_LINES];
    logic [4:0]    line_tag_q [NUM_LINES];
    logic [31:0]   line_data [NUM_LINES * LINE_WORDS];
    logic [31:0]   mem_image [MEM_WORDS];
    logic [7:0]    victim_sel;
    cache_result_t pending [$];
    int            errors;

    function new();
      foreach (line_ok[i]) begin
        line_ok[i]    = 1'b0;
        line_mod[i]   = 1'b0;
        line_tag_q[i] = '0;
      end
      foreach (line_data[i]) line_data[i] = '0;
      foreach (mem_image[i]) mem_image[i] = '0;
      victim_sel = LFSR_RESET;
      errors = 0;
    endfunction

    // Runs one access against the shadow cache and queues its result.
    function void note_access(logic cmd, logic [14:0] addr, logic [31:0] wd,
                              logic [31:0] wm);
      logic [3:0]    set_idx;
      logic [4:0]    tag_in;
      logic [3:0]    woff;
      int            base;
      int            line;
      int            idx;
      int            blk;
      bit            hit;
      bit            found;
      bit            wb;
      cache_result_t res;
      set_idx = addr[9:6];
      tag_in  = addr[14:10];
      woff    = addr[5:2];
      base    = int'(set_idx) * NUM_WAYS;
      line    = 0;
      hit     = 1'b0;
      found   = 1'b0;
      wb      = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!hit && line_ok[base + w] && line_tag_q[base + w] == tag_in) begin
          line = base + w;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!found && !line_ok[base + w]) begin
            line  = base + w;
            found = 1'b1;
          end
        end
        if (!found) begin
          line = base + int'(victim_sel[1:0]);
          victim_sel = {1'b0, victim_sel[7:1]} ^ (victim_sel[0] ? LFSR_TAPS : 8'h00);
          if (line_mod[line]) begin
            blk = int'({line_tag_q[line], set_idx});
            for (int k = 0; k < LINE_WORDS; k++)
              mem_image[blk * LINE_WORDS + k] = line_data[line * LINE_WORDS + k];
            wb = 1'b1;
          end
        end
        blk = int'({tag_in, set_idx});
        for (int k = 0; k < LINE_WORDS; k++)
          line_data[line * LINE_WORDS + k] = mem_image[blk * LINE_WORDS + k];
        line_ok[line]    = 1'b1;
        line_tag_q[line] = tag_in;
        line_mod[line]   = 1'b0;
      end
      idx = line * LINE_WORDS + int'(woff);
      if (cmd == CMD_WRITE) begin
        line_data[idx] = (line_data[idx] & ~wm) | (wd & wm);
        line_mod[line] = 1'b1;
      end
      res.word = line_data[idx];
      res.hit  = hit;
      res.wb   = wb;
      pending.push_back(res);
    endfunction

    function void check_result(logic [31:0] rd, logic [1:0] flags);
      cache_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transfer word=%h flags=%b", $time, rd, flags);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (rd !== exp_r.word) begin
        $display("%0t: read_word mismatch expected %h actual %h", $time, exp_r.word, rd);
        errors++;
      end
      if (flags[0] !== exp_r.hit) begin
        $display("%0t: was_hit mismatch expected %b actual %b", $time, exp_r.hit, flags[0]);
        errors++;
      end
      if (flags[1] !== exp_r.wb) begin
        $display("%0t: did_writeback mismatch expected %b actual %b", $time, exp_r.wb,
                 flags[1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [79:0] s_tdata;   // byte_addr[14:0], write_word[46:15], write_mask[78:47]
  logic        s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // read_word[31:0]
  logic [1:0]  m_tuser;   // was_hit[0], did_writeback[1]

  cache_scoreboard sb = new();
  bit              calm;
  int              stall_left;
  longint          cycles;

  set_assoc_writeback_cache #(
    .NUM_SETS  (TB_NUM_SETS),
    .MEM_BYTES (TB_MEM_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_access(logic cmd, logic [14:0] addr, logic [31:0] wd,
                             logic [31:0] wm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, wm, wd, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_access(cmd, addr, wd, wm);
    @(negedge clk);
  endtask

  // random access; most of them hammer a few sets with more tags than ways
  task automatic send_random();
    logic        cmd;
    logic [14:0] addr;
    logic [31:0] wm;
    logic [3:0]  hot_set;
    int          r;
    cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    addr = 15'($urandom_range(0, 32767));
    if ($urandom_range(0, 99) < 65) begin
      r = $urandom_range(0, 3);
      hot_set = (r == 0) ? 4'd0 : (r == 1) ? 4'd7 : (r == 2) ? 4'd15 : 4'($urandom);
      addr[9:6]   = hot_set;
      addr[14:10] = ($urandom_range(0, 9) == 0) ? 5'd31 : 5'($urandom_range(0, 5));
    end
    r = $urandom_range(0, 9);
    wm = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'h0 : $urandom;
    send_access(cmd, addr, $urandom, wm);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("set_assoc_writeback_cache verification failed");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = CMD_READ;
    m_tready   = 1'b0;
    calm       = 1'b0;
    stall_left = 0;
    cycles     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: cold miss, hits, zero mask, top address
    send_access(CMD_READ,  15'h0000, 32'h0, 32'h0);
    send_access(CMD_WRITE, 15'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(CMD_WRITE, 15'h0003, 32'h0, 32'h0);
    send_access(CMD_READ,  15'h7FFF, 32'h0, 32'h0);
    send_access(CMD_WRITE, 15'h7FFC, 32'hA5A5_A5A5, 32'h0F0F_0F0F);
    send_access(CMD_READ,  15'h7FFD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill set 0 with dirty lines, then force dirty and clean evictions
    for (int t = 1; t <= 4; t++)
      send_access(CMD_WRITE, 15'(t << 10) | 15'h0004, 32'h1111_1111 * t, 32'hFFFF_FFFF);
    for (int t = 5; t <= 9; t++)
      send_access(CMD_READ, 15'(t << 10) | 15'h0008, 32'h0, 32'h0);
    for (int t = 0; t <= 4; t++)
      send_access(CMD_READ, 15'(t << 10) | 15'h0004, 32'h0, 32'h0);
    send_access(CMD_READ,  15'h0000, 32'h0, 32'h0);
    send_access(CMD_WRITE, 15'h7FFC, 32'h0000_0000, 32'hFFFF_FFFF);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i % 300) < 40;
      send_random();
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("set_assoc_writeback_cache verification clean");
    end else begin
      $display("set_assoc_writeback_cache verification failed");
    end
    $finish;
  end

endmodule
